// ===== hw/rtl/dfg_pkg.sv =====
// Shared constants, widths and types for the density field gradient unit.
package dfg_pkg;

  // Grid and band geometry
  localparam int GRID_X    = 4096;
  localparam int GRID_Y    = 512;
  localparam int BAND_COLS = 16;
  localparam int MAX_SPAN  = 8;

  localparam int COL_W  = $clog2(BAND_COLS);
  localparam int ROW_W  = $clog2(GRID_Y);
  localparam int GX_W   = $clog2(GRID_X);
  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int ADDR_W = COL_W + ROW_W;

  // Shared multiplier and accumulator
  localparam int MUL_W = 33;
  localparam int ACC_W = 160;

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X       = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y       = 3'd1;
  localparam logic [2:0] REG_BIN_WIDTH      = 3'd2;
  localparam logic [2:0] REG_BIN_HEIGHT     = 3'd3;
  localparam logic [2:0] REG_INV_BIN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_INV_BIN_HEIGHT = 3'd5;
  localparam logic [2:0] REG_WEIGHT_SCALE   = 3'd6;
  localparam logic [2:0] REG_BAND_FIRST_COL = 3'd7;

  // Control of the multiply-accumulate unit
  typedef struct packed {
    logic       clr;  // zero the accumulator
    logic       en;   // add the shifted product
    logic [1:0] sh;   // limb offset of the product
  } mac_ctl_t;

endpackage

// ===== hw/rtl/density_field_gradient_unit.sv =====
// Density field gradient unit: field store plus sequenced bin-overlap gradient.
// A load transfer writes the field store directly. A cell is sequenced through
//   its bin range, then each column and each row of it (kc columns, kb of them
//   in the band, hc rows, each at most 8), all on the one shared multiplier.
// The unit takes one item at a time; the result sits in an output register so the
// next item is taken while it waits. Reset restores register defaults; the
// field store is not cleared.
module density_field_gradient_unit import dfg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  // input items
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [3:0]          band_column,
  input  logic [8:0]          bin_row,
  input  logic signed [31:0]  field_x_value,
  input  logic signed [31:0]  field_y_value,
  input  logic [31:0]         cell_x,
  input  logic [31:0]         cell_y,
  input  logic signed [31:0]  shift_x,
  input  logic signed [31:0]  shift_y,
  input  logic [31:0]         extent_x,
  input  logic [31:0]         extent_y,
  input  logic [15:0]         density_ratio,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  grad_x,
  output logic signed [31:0]  grad_y
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_BIN_B = 4'd1;
  localparam logic [3:0] ST_BIN_A = 4'd2;
  localparam logic [3:0] ST_RANGE = 4'd3;
  localparam logic [3:0] ST_WPREP = 4'd4;
  localparam logic [3:0] ST_COL   = 4'd5;
  localparam logic [3:0] ST_OX    = 4'd6;
  localparam logic [3:0] ST_BMUL  = 4'd7;
  localparam logic [3:0] ST_ROW   = 4'd8;
  localparam logic [3:0] ST_OY    = 4'd9;
  localparam logic [3:0] ST_CMUL  = 4'd10;
  localparam logic [3:0] ST_ROUND = 4'd11;
  localparam logic [3:0] ST_GX    = 4'd12;
  localparam logic [3:0] ST_GY    = 4'd13;
  localparam logic [3:0] ST_DONE  = 4'd14;

  // control
  logic [3:0]  state, state_next;

  // configuration registers
  logic [31:0]     origin_x, origin_y, bin_width, bin_height;
  logic [31:0]     inv_bin_width, inv_bin_height, weight_scale;
  logic [GX_W-1:0] band_first_column;

  // cell operands
  logic signed [33:0] px0, py0;
  logic signed [35:0] xt, yt;
  logic [15:0]        ratio;

  // bin range
  logic [1:0]          q;
  logic [31:0]         tb;
  logic signed [37:0]  bn [4];
  logic [GX_W-1:0]     bxl;
  logic [ROW_W-1:0]    byl;
  logic [SPAN_W-1:0]   kc, hc, k, h;

  // overlap and weight
  logic [47:0]       wa;
  logic [44:0]       lo;
  logic [41:0]       ylo;
  logic              ox_neg, oy_neg;
  logic [COL_W-1:0]  lcol;
  logic [95:0]       opx;
  logic [63:0]       opy;
  logic [1:0]        li, li_last;
  logic              lj;
  logic signed [31:0] w;
  logic [31:0]       gx, gy;

  // field store
  logic [31:0]       fx_mem [1 << ADDR_W];
  logic [31:0]       fy_mem [1 << ADDR_W];
  logic [31:0]       fx_rd, fy_rd;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  // shared unit
  mac_ctl_t                  ctl;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic [ACC_W-1:0]          acc;

  // combinational helpers
  logic signed [36:0] d;
  logic [31:0]        inv_sel;
  logic               d_neg;
  logic [36:0]        d_mag;
  logic [52:0]        t_sum;
  logic signed [37:0] t_val;
  logic signed [37:0] xl, xh, yl, yh;
  logic signed [38:0] xdiff, ydiff;
  logic [SPAN_W-1:0]  kc_v, hc_v;
  logic [GX_W:0]      col;
  logic [GX_W:0]      lc;
  logic               in_band;
  logic [45:0]        hi;
  logic [42:0]        yhi;
  logic signed [47:0] top_v, bot_v, ox, oy;
  logic [47:0]        ox_mag, oy_mag;
  logic [ROW_W-1:0]   row;
  logic [ACC_W-1:0]   rnd;
  logic               sat;
  logic [33:0]        m;
  logic signed [31:0] w_v;
  logic               in_xfer, last_limb, row_last, col_last;

  dfg_mac u_mac (
    .clk  (clk),
    .ctl  (ctl),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod),
    .acc  (acc)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;

  // bin index of one range bound: trunc(d * inv / 2^32)
  always_comb begin
    unique case (q)
      2'd0: begin
        d = 37'(px0) - $signed({5'b0, origin_x});
        inv_sel = inv_bin_width;
      end
      2'd1: begin
        d = 37'(xt) - $signed({5'b0, origin_x});
        inv_sel = inv_bin_width;
      end
      2'd2: begin
        d = 37'(py0) - $signed({5'b0, origin_y});
        inv_sel = inv_bin_height;
      end
      default: begin
        d = 37'(yt) - $signed({5'b0, origin_y});
        inv_sel = inv_bin_height;
      end
    endcase
    d_neg = d[36];
    d_mag = d_neg ? 37'(-d) : 37'(d);
    t_sum = 53'(prod[51:0]) + 53'(tb);
    t_val = $signed({1'b0, t_sum[52:16]});
  end

  // clamp the range to the grid and the span limit
  always_comb begin
    xl = bn[0][37] ? 38'sd0 : bn[0];
    xh = (bn[1] > 38'(GRID_X)) ? 38'(GRID_X) : bn[1];
    yl = bn[2][37] ? 38'sd0 : bn[2];
    yh = (bn[3] > 38'(GRID_Y)) ? 38'(GRID_Y) : bn[3];
    xdiff = 39'(xh) - 39'(xl);
    ydiff = 39'(yh) - 39'(yl);
    if (xdiff <= 39'sd0) begin
      kc_v = '0;
    end else if (xdiff > 39'(MAX_SPAN)) begin
      kc_v = SPAN_W'(MAX_SPAN);
    end else begin
      kc_v = xdiff[SPAN_W-1:0];
    end
    if (ydiff <= 39'sd0) begin
      hc_v = '0;
    end else if (ydiff > 39'(MAX_SPAN)) begin
      hc_v = SPAN_W'(MAX_SPAN);
    end else begin
      hc_v = ydiff[SPAN_W-1:0];
    end
  end

  // column overlap and band membership
  always_comb begin
    col = (GX_W+1)'(bxl) + (GX_W+1)'(k);
    lc  = col - (GX_W+1)'(band_first_column);
    in_band = (col >= (GX_W+1)'(band_first_column)) && (lc < (GX_W+1)'(BAND_COLS));
    hi = 46'(lo) + 46'(bin_width);
    top_v = (48'(xt) < $signed({2'b0, hi})) ? 48'(xt) : $signed({2'b0, hi});
    bot_v = (48'(px0) > $signed({3'b0, lo})) ? 48'(px0) : $signed({3'b0, lo});
    ox = top_v - bot_v;
    ox_mag = ox[47] ? 48'(-ox) : 48'(ox);
  end

  // row overlap
  always_comb begin
    row = byl + ROW_W'(h);
    yhi = 43'(ylo) + 43'(bin_height);
    oy = ((48'(yt) < $signed({5'b0, yhi})) ? 48'(yt) : $signed({5'b0, yhi}))
       - ((48'(py0) > $signed({6'b0, ylo})) ? 48'(py0) : $signed({6'b0, ylo}));
    oy_mag = oy[47] ? 48'(-oy) : 48'(oy);
  end

  // round half away from zero, saturate to 32 bits
  always_comb begin
    rnd = acc + (ACC_W'(1) << 61);
    sat = |rnd[ACC_W-1:96];
    m   = rnd[95:62];
    if (ox_neg ^ oy_neg) begin
      if (sat || m >= 34'h080000000) begin
        w_v = 32'sh80000000;
      end else begin
        w_v = 32'(-$signed({1'b0, m}));
      end
    end else begin
      if (sat || m > 34'h07fffffff) begin
        w_v = 32'sh7fffffff;
      end else begin
        w_v = $signed(m[31:0]);
      end
    end
  end

  // multiplier operands and accumulator control
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    ctl   = '0;
    unique case (state)
      ST_BIN_B: begin
        mul_a = MUL_W'(d_mag[15:0]);
        mul_b = MUL_W'(inv_sel);
      end
      ST_BIN_A: begin
        mul_a = MUL_W'(d_mag[35:16]);
        mul_b = MUL_W'(inv_sel);
      end
      ST_WPREP: begin
        mul_a = MUL_W'(ratio);
        mul_b = MUL_W'(weight_scale);
      end
      ST_COL: begin
        mul_a = MUL_W'(col);
        mul_b = MUL_W'(bin_width);
      end
      ST_ROW: begin
        mul_a = MUL_W'(row);
        mul_b = MUL_W'(bin_height);
      end
      ST_OX: begin
        ctl.clr = 1'b1;
      end
      ST_OY: begin
        ctl.clr = 1'b1;
      end
      ST_BMUL, ST_CMUL: begin
        mul_a  = MUL_W'(opx[{li, 5'b0} +: 32]);
        mul_b  = MUL_W'(opy[{lj, 5'b0} +: 32]);
        ctl.en = 1'b1;
        ctl.sh = li + {1'b0, lj};
      end
      ST_GX: begin
        mul_a = MUL_W'(w);
        mul_b = $signed({fx_rd[31], fx_rd});
      end
      ST_GY: begin
        mul_a = MUL_W'(w);
        mul_b = $signed({fy_rd[31], fy_rd});
      end
      default: begin
      end
    endcase
  end

  assign last_limb = lj && (li == li_last);
  assign row_last  = (h + 1'b1) == hc;
  assign col_last  = (k + 1'b1) == kc;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && cmd) begin
          state_next = ST_BIN_B;
        end
      end
      ST_BIN_B: state_next = ST_BIN_A;
      ST_BIN_A: state_next = (q == 2'd3) ? ST_RANGE : ST_BIN_B;
      ST_RANGE: state_next = (kc_v == '0 || hc_v == '0) ? ST_DONE : ST_WPREP;
      ST_WPREP: state_next = ST_COL;
      ST_COL:   state_next = ST_OX;
      ST_OX: begin
        if (in_band) begin
          state_next = ST_BMUL;
        end else begin
          state_next = col_last ? ST_DONE : ST_COL;
        end
      end
      ST_BMUL:  state_next = last_limb ? ST_ROW : ST_BMUL;
      ST_ROW:   state_next = ST_OY;
      ST_OY:    state_next = ST_CMUL;
      ST_CMUL:  state_next = last_limb ? ST_ROUND : ST_CMUL;
      ST_ROUND: state_next = ST_GX;
      ST_GX:    state_next = ST_GY;
      ST_GY: begin
        if (!row_last) begin
          state_next = ST_ROW;
        end else begin
          state_next = col_last ? ST_DONE : ST_COL;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      origin_x          <= 32'd0;
      origin_y          <= 32'd0;
      bin_width         <= 32'd65536;
      bin_height        <= 32'd65536;
      inv_bin_width     <= 32'd65536;
      inv_bin_height    <= 32'd65536;
      weight_scale      <= 32'd65536;
      band_first_column <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ORIGIN_X:       origin_x          <= cfg_data;
          REG_ORIGIN_Y:       origin_y          <= cfg_data;
          REG_BIN_WIDTH:      bin_width         <= cfg_data;
          REG_BIN_HEIGHT:     bin_height        <= cfg_data;
          REG_INV_BIN_WIDTH:  inv_bin_width     <= cfg_data;
          REG_INV_BIN_HEIGHT: inv_bin_height    <= cfg_data;
          REG_WEIGHT_SCALE:   weight_scale      <= cfg_data;
          REG_BAND_FIRST_COL: band_first_column <= cfg_data[GX_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_en <= 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && cmd) begin
          px0   <= 34'(cell_x) + 34'(shift_x);
          py0   <= 34'(cell_y) + 34'(shift_y);
          xt    <= 36'(cell_x) + 36'(shift_x) + 36'(extent_x);
          yt    <= 36'(cell_y) + 36'(shift_y) + 36'(extent_y);
          ratio <= density_ratio;
          q     <= 2'd0;
          gx    <= '0;
          gy    <= '0;
        end
      end
      ST_BIN_B: begin
        tb <= prod[47:16];
      end
      ST_BIN_A: begin
        bn[q] <= (d_neg ? -t_val : t_val) + (q[0] ? 38'sd1 : 38'sd0);
        q <= q + 2'd1;
      end
      ST_RANGE: begin
        bxl <= xl[GX_W-1:0];
        byl <= yl[ROW_W-1:0];
        kc  <= kc_v;
        hc  <= hc_v;
        k   <= '0;
      end
      ST_WPREP: begin
        wa <= prod[47:0];
      end
      ST_COL: begin
        lo <= 45'(prod[43:0]) + 45'(origin_x);
      end
      ST_OX: begin
        lcol    <= lc[COL_W-1:0];
        ox_neg  <= ox[47];
        opx     <= 96'(wa);
        opy     <= 64'(ox_mag);
        li      <= 2'd0;
        lj      <= 1'b0;
        li_last <= 2'd1;
        h       <= '0;
        if (!in_band) begin
          k <= k + 1'b1;
        end
      end
      ST_BMUL, ST_CMUL: begin
        lj <= ~lj;
        if (lj) begin
          li <= li + 2'd1;
        end
      end
      ST_ROW: begin
        if (h == '0) begin
          opx <= acc[95:0];
        end
        ylo <= 42'(prod[40:0]) + 42'(origin_y);
      end
      ST_OY: begin
        oy_neg  <= oy[47];
        opy     <= 64'(oy_mag);
        li      <= 2'd0;
        lj      <= 1'b0;
        li_last <= 2'd2;
        rd_en   <= 1'b1;
      end
      ST_ROUND: begin
        w <= w_v;
      end
      ST_GX: begin
        gx <= gx + prod[46:15];
      end
      ST_GY: begin
        gy <= gy + prod[46:15];
        h  <= h + 1'b1;
        if (row_last) begin
          k <= k + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          grad_x <= gx;
          grad_y <= gy;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_addr = {lcol, row};

  // field store: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (in_xfer && !cmd && (32'(band_column) < BAND_COLS) && (32'(bin_row) < GRID_Y)) begin
      fx_mem[{band_column[COL_W-1:0], bin_row[ROW_W-1:0]}] <= field_x_value;
      fy_mem[{band_column[COL_W-1:0], bin_row[ROW_W-1:0]}] <= field_y_value;
    end
    if (rd_en) begin
      fx_rd <= fx_mem[rd_addr];
      fy_rd <= fy_mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/dfg_mac.sv =====
// Shared 33x33 signed multiplier with a limb-shifted wide accumulator.
module dfg_mac import dfg_pkg::*; (
  input  logic                        clk,
  input  mac_ctl_t                    ctl,
  input  logic signed [MUL_W-1:0]     a,
  input  logic signed [MUL_W-1:0]     b,
  output logic signed [2*MUL_W-1:0]   prod,
  output logic [ACC_W-1:0]            acc
);

  logic [ACC_W-1:0] addend;

  // one multiplier, shared by every multiply step of the sequencer
  assign prod = a * b;

  // place the 64-bit limb product at its 32-bit limb offset
  always_comb begin
    addend = ACC_W'(prod[63:0]) << {ctl.sh, 5'b0};
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.en) begin
      acc <= acc + addend;
    end
  end

endmodule
